[rtl/apr_pkg.sv]
`timescale 1ns / 1ps

package apr_pkg;

  localparam int          MAX_PAYLOAD_DEF = 20;
  localparam int          CFG_IDX_W       = 2;
  localparam logic [7:0]  HEADER_BYTE     = 8'h80;
  localparam logic [15:0] CRC_START       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'h1021;

  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_MASK = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_MASK = CFG_IDX_W'(1);

  localparam logic [2:0] STAT_GOOD      = 3'd0;
  localparam logic [2:0] STAT_HEADER    = 3'd1;
  localparam logic [2:0] STAT_ZERO_LEN  = 3'd2;
  localparam logic [2:0] STAT_LEN_BIG   = 3'd3;
  localparam logic [2:0] STAT_CHECKSUM  = 3'd4;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ADDR,
    PH_LEN,
    PH_DATA,
    PH_CRC,
    PH_CKLO,
    PH_CKHI,
    PH_RD,
    PH_EMIT
  } phase_t;

  typedef struct packed {
    logic clear;
    logic start;
  } crc_ctl_t;

endpackage

[rtl/addressed_packet_receiver_crc16_top.sv]
`timescale 1ns / 1ps
// channel   signals                         direction   beat taken when
// in        in_valid, in_stall, in_rx_byte  sink        in_valid && !in_stall
// out       out_valid, out_stall, out_*     source      out_valid && !out_stall
// cfg       cfg_valid, cfg_ready, cfg_*     sink        cfg_valid && cfg_ready
//
// header, address, length and checksum bytes are not held by the crc unit
// each payload byte is taken, then passes through the bit-serial crc unit before the next is taken
// a good packet gives one result per payload byte: a registered buffer read, then the emit, before the next read
// synchronous active-low reset; the payload buffer is not cleared
// in_stall is high while a payload byte is in the crc unit, while results drain,
// and while a held result is stalled

module addressed_packet_receiver_crc16_top #(
  parameter int MAX_PAYLOAD = apr_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [7:0]                     out_payload_byte,
  output logic [4:0]                     out_byte_index,
  output logic [7:0]                     out_packet_length,
  output logic                           out_respond_requested,
  output logic                           out_last,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [apr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [7:0]                     cfg_wdata
);
  import apr_pkg::*;

  localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);

  phase_t ph_r, ph_nxt;

  logic [7:0]       slave_mask_r, board_mask_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       cklo_r, cklo_nxt;
  logic             rsp_r, rsp_nxt;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [7:0]       out_byte_r;
  logic [4:0]       out_idx_r;
  logic [7:0]       out_len_r;
  logic             out_rsp_r;
  logic             out_last_r;

  logic             acc, out_free, selected, len_bad, crc_ok, rd_last;
  logic             load;
  logic [2:0]       ld_status;
  logic [7:0]       ld_byte;
  logic [4:0]       ld_idx;
  logic [7:0]       ld_len;
  logic             ld_rsp, ld_last;

  crc_ctl_t         crc_ctl;
  logic             crc_done;
  logic [15:0]      crc_val;
  logic             wr_en, rd_en;
  logic [7:0]       rd_data;

  apr_crc_unit u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (crc_ctl),
    .data_in (in_rx_byte),
    .done    (crc_done),
    .crc     (crc_val)
  );

  apr_payload_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (in_rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  assign cfg_ready = 1'b1;

  assign out_free = !out_valid_r || !out_stall;
  assign acc      = in_valid && !in_stall;
  assign selected = ((in_rx_byte & slave_mask_r) != 8'd0) &&
                    ((in_rx_byte & board_mask_r) != 8'd0);
  assign len_bad  = (in_rx_byte == 8'd0) || (in_rx_byte > 8'(MAX_PAYLOAD));
  assign crc_ok   = ({in_rx_byte, cklo_r} == crc_val);
  assign rd_last  = ((8'(rd_idx_r) + 8'd1) == len_r);

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      PH_IDLE: begin
        if (acc) begin
          ph_nxt = (in_rx_byte == HEADER_BYTE) ? PH_ADDR : PH_IDLE;
        end
      end
      PH_ADDR: begin
        if (acc) begin
          ph_nxt = selected ? PH_LEN : PH_IDLE;
        end
      end
      PH_LEN: begin
        if (acc) begin
          ph_nxt = len_bad ? PH_IDLE : PH_DATA;
        end
      end
      PH_DATA: begin
        if (acc) begin
          ph_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        if (crc_done) begin
          ph_nxt = (8'(cnt_r) >= len_r) ? PH_CKLO : PH_DATA;
        end
      end
      PH_CKLO: begin
        if (acc) begin
          ph_nxt = PH_CKHI;
        end
      end
      PH_CKHI: begin
        if (acc) begin
          ph_nxt = crc_ok ? PH_RD : PH_IDLE;
        end
      end
      PH_RD: begin
        ph_nxt = PH_EMIT;
      end
      PH_EMIT: begin
        if (out_free) begin
          ph_nxt = rd_last ? PH_IDLE : PH_RD;
        end
      end
      default: begin
        ph_nxt = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    crc_ctl.clear = 1'b0;
    crc_ctl.start = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    load          = 1'b0;
    ld_status     = STAT_GOOD;
    ld_byte       = 8'd0;
    ld_idx        = 5'd0;
    ld_len        = 8'd0;
    ld_rsp        = 1'b0;
    ld_last       = 1'b1;
    cnt_nxt       = cnt_r;
    rd_idx_nxt    = rd_idx_r;
    len_nxt       = len_r;
    cklo_nxt      = cklo_r;
    rsp_nxt       = rsp_r;
    case (ph_r)
      PH_IDLE: begin
        in_stall = out_valid_r && out_stall;
        if (acc) begin
          if (in_rx_byte == HEADER_BYTE) begin
            crc_ctl.clear = 1'b1;
          end else begin
            load      = 1'b1;
            ld_status = STAT_HEADER;
            rsp_nxt   = 1'b0;
            cnt_nxt   = '0;
          end
        end
      end
      PH_ADDR: begin
        in_stall = out_valid_r && out_stall;
        if (acc) begin
          if (selected) begin
            rsp_nxt = in_rx_byte[7];
          end else begin
            rsp_nxt = 1'b0;
            cnt_nxt = '0;
          end
        end
      end
      PH_LEN: begin
        in_stall = out_valid_r && out_stall;
        if (acc) begin
          len_nxt = in_rx_byte;
          cnt_nxt = '0;
          if (len_bad) begin
            load      = 1'b1;
            ld_status = (in_rx_byte == 8'd0) ? STAT_ZERO_LEN : STAT_LEN_BIG;
            ld_len    = in_rx_byte;
            ld_rsp    = rsp_r;
            rsp_nxt   = 1'b0;
          end
        end
      end
      PH_DATA: begin
        in_stall = out_valid_r && out_stall;
        if (acc) begin
          wr_en         = 1'b1;
          crc_ctl.start = 1'b1;
          cnt_nxt       = cnt_r + CNT_W'(1);
        end
      end
      PH_CKLO: begin
        in_stall = out_valid_r && out_stall;
        if (acc) begin
          cklo_nxt = in_rx_byte;
        end
      end
      PH_CKHI: begin
        in_stall = out_valid_r && out_stall;
        if (acc) begin
          if (crc_ok) begin
            rd_idx_nxt = '0;
          end else begin
            load      = 1'b1;
            ld_status = STAT_CHECKSUM;
            ld_len    = len_r;
            ld_rsp    = rsp_r;
            rsp_nxt   = 1'b0;
            cnt_nxt   = '0;
          end
        end
      end
      PH_RD: begin
        rd_en = 1'b1;
      end
      PH_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          ld_status  = STAT_GOOD;
          ld_byte    = rd_data;
          ld_idx     = 5'(rd_idx_r);
          ld_len     = len_r;
          ld_rsp     = rsp_r;
          ld_last    = rd_last;
          rd_idx_nxt = rd_idx_r + CNT_W'(1);
          if (rd_last) begin
            rsp_nxt       = 1'b0;
            cnt_nxt       = '0;
            crc_ctl.clear = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r         <= PH_IDLE;
      slave_mask_r <= 8'd1;
      board_mask_r <= 8'd255;
      cnt_r        <= '0;
      rd_idx_r     <= '0;
      len_r        <= 8'd0;
      cklo_r       <= 8'd0;
      rsp_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ph_r     <= ph_nxt;
      cnt_r    <= cnt_nxt;
      rd_idx_r <= rd_idx_nxt;
      len_r    <= len_nxt;
      cklo_r   <= cklo_nxt;
      rsp_r    <= rsp_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLAVE_MASK: slave_mask_r <= cfg_wdata;
          REG_BOARD_MASK: board_mask_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      out_status_r <= ld_status;
      out_byte_r   <= ld_byte;
      out_idx_r    <= ld_idx;
      out_len_r    <= ld_len;
      out_rsp_r    <= ld_rsp;
      out_last_r   <= ld_last;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_payload_byte      = out_byte_r;
  assign out_byte_index        = out_idx_r;
  assign out_packet_length     = out_len_r;
  assign out_respond_requested = out_rsp_r;
  assign out_last              = out_last_r;

endmodule

[rtl/apr_crc_unit.sv]
`timescale 1ns / 1ps

module apr_crc_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  apr_pkg::crc_ctl_t ctl,
  input  logic [7:0]        data_in,
  output logic              done,
  output logic [15:0]       crc
);
  import apr_pkg::*;

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  sh_r, sh_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        fb;

  // one bit per cycle, msb first
  always_comb begin
    fb       = crc_r[15] ^ sh_r[7];
    crc_nxt  = crc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (ctl.clear) begin
      crc_nxt  = CRC_START;
      busy_nxt = 1'b0;
    end else if (ctl.start) begin
      sh_nxt   = data_in;
      cnt_nxt  = 3'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      crc_nxt = {crc_r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
      sh_nxt  = {sh_r[6:0], 1'b0};
      cnt_nxt = cnt_r + 3'd1;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_START;
      cnt_r  <= 3'd0;
      busy_r <= 1'b0;
    end else begin
      crc_r  <= crc_nxt;
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
    sh_r <= sh_nxt;
  end

  assign done = busy_r && (cnt_r == 3'd7);
  assign crc  = crc_r;

endmodule

[rtl/apr_payload_buf.sv]
`timescale 1ns / 1ps

module apr_payload_buf #(
  parameter int DEPTH = apr_pkg::MAX_PAYLOAD_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[tb/tb_addressed_packet_receiver_crc16_top.sv]
`timescale 1ns / 1ps

module tb_addressed_packet_receiver_crc16_top;
  import apr_pkg::*;

  localparam int MAX_LEN = MAX_PAYLOAD_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 60;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic [4:0] byte_index;
    logic [7:0] packet_length;
    logic       respond_requested;
    logic       last;
  } rx_result_t;

  typedef logic [7:0] octet_q_t[$];

  typedef enum {
    PK_GOOD,
    PK_BAD_CRC,
    PK_ZERO_LEN,
    PK_LONG_LEN,
    PK_UNSELECTED,
    PK_NOISE,
    PK_TRUNCATED
  } frame_kind_t;

  class frame_scoreboard;
    phase_t      rx_phase;
    logic [7:0]  slave_mask;
    logic [7:0]  board_mask;
    logic [7:0]  data_count;
    logic [7:0]  frame_len;
    logic [7:0]  crc_lo;
    logic [7:0]  payload_mem [MAX_LEN];
    logic [15:0] crc_acc;
    logic        respond;
    rx_result_t  expected_q[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      slave_mask   = 8'h01;
      board_mask   = 8'hFF;
      frame_len    = 8'd0;
      crc_lo       = 8'd0;
      mismatches   = 0;
      results_seen = 0;
      back_to_idle();
    endfunction

    static function logic [15:0] crc_ccitt_byte(logic [15:0] crc, logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++)
        c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
    endfunction

    function void back_to_idle();
      rx_phase   = PH_IDLE;
      data_count = 8'd0;
      respond    = 1'b0;
      crc_acc    = CRC_START;
    endfunction

    function void push_error(logic [2:0] st, logic [7:0] len, logic rsp);
      expected_q.push_back('{st, 8'd0, 5'd0, len, rsp, 1'b1});
      back_to_idle();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
      if (idx == REG_SLAVE_MASK) begin
        slave_mask = data;
      end else if (idx == REG_BOARD_MASK) begin
        board_mask = data;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_rx_byte(logic [7:0] b);
      int n;
      case (rx_phase)
        PH_IDLE: begin
          if (b != HEADER_BYTE) begin
            push_error(STAT_HEADER, 8'd0, 1'b0);
          end else begin
            crc_acc  = CRC_START;
            rx_phase = PH_ADDR;
          end
        end
        PH_ADDR: begin
          if ((b & slave_mask) == 8'd0 || (b & board_mask) == 8'd0) begin
            back_to_idle();
          end else begin
            respond  = b[7];
            rx_phase = PH_LEN;
          end
        end
        PH_LEN: begin
          frame_len = b;
          if (b == 8'd0) begin
            push_error(STAT_ZERO_LEN, b, respond);
          end else if (b > MAX_LEN) begin
            push_error(STAT_LEN_BIG, b, respond);
          end else begin
            data_count = 8'd0;
            rx_phase   = PH_DATA;
          end
        end
        PH_DATA: begin
          if (data_count < MAX_LEN) payload_mem[data_count] = b;
          crc_acc    = crc_ccitt_byte(crc_acc, b);
          data_count = data_count + 8'd1;
          if (data_count >= frame_len) rx_phase = PH_CKLO;
        end
        PH_CKLO: begin
          crc_lo   = b;
          rx_phase = PH_CKHI;
        end
        PH_CKHI: begin
          if ({b, crc_lo} != crc_acc) begin
            push_error(STAT_CHECKSUM, frame_len, respond);
          end else begin
            n = (frame_len > MAX_LEN) ? MAX_LEN : int'(frame_len);
            for (int i = 0; i < n; i++)
              expected_q.push_back('{STAT_GOOD, payload_mem[i], 5'(i), frame_len,
                                     respond, (i == n - 1)});
            back_to_idle();
          end
        end
        default: back_to_idle();
      endcase
    endfunction

    function void compare_field(string field, int want, int got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(rx_result_t got);
      rx_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with nothing expected, expected none, actual %h",
                 $time, got);
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("packet_length", want.packet_length, got.packet_length);
      compare_field("respond_requested", want.respond_requested, got.respond_requested);
      compare_field("last", want.last, got.last);
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_rx_byte;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_status;
  logic [7:0]           out_payload_byte;
  logic [4:0]           out_byte_index;
  logic [7:0]           out_packet_length;
  logic                 out_respond_requested;
  logic                 out_last;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_wdata;

  frame_scoreboard sb;
  bit              dense;
  bit              long_hold_req;
  int unsigned     holds_done;
  int unsigned     bytes_sent;
  int unsigned     settings_used;
  logic [7:0]      cur_slave;
  logic [7:0]      cur_board;

  addressed_packet_receiver_crc16_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_status            (out_status),
    .out_payload_byte      (out_payload_byte),
    .out_byte_index        (out_byte_index),
    .out_packet_length     (out_packet_length),
    .out_respond_requested (out_respond_requested),
    .out_last              (out_last),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = dense ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_all(input octet_q_t q);
    foreach (q[i]) send_byte(q[i]);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data,
                           input bit keep_valid);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    if (!keep_valid) cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    dense = 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // back to idle: zero is unselected as address, an error as length
  task automatic flush_frame();
    while (sb.rx_phase != PH_IDLE) send_byte(8'h00);
  endtask

  function automatic octet_q_t frame_bytes(logic [7:0] addr, logic [7:0] len,
                                           logic [15:0] crc_flip);
    octet_q_t    q;
    logic [15:0] crc;
    logic [7:0]  d;
    bit          extremes;
    q = {HEADER_BYTE, addr, len};
    crc = CRC_START;
    extremes = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      if (extremes) d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else d = 8'($urandom_range(0, 255));
      q.push_back(d);
      crc = frame_scoreboard::crc_ccitt_byte(crc, d);
    end
    crc ^= crc_flip;
    q.push_back(crc[7:0]);
    q.push_back(crc[15:8]);
    return q;
  endfunction

  function automatic logic [7:0] pick_addr(bit want_sel);
    logic [7:0] a;
    a = 8'h00;
    for (int t = 0; t < 64; t++) begin
      a = 8'($urandom_range(0, 255));
      if ((((a & cur_slave) != 0) && ((a & cur_board) != 0)) == want_sel) return a;
    end
    return a;
  endfunction

  function automatic frame_kind_t pick_kind();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return PK_GOOD;
    if (r < 14) return PK_BAD_CRC;
    if (r < 15) return PK_ZERO_LEN;
    if (r < 16) return PK_LONG_LEN;
    if (r < 17) return PK_UNSELECTED;
    if (r < 18) return PK_NOISE;
    return PK_TRUNCATED;
  endfunction

  task automatic random_traffic(input int budget, input bit pressure);
    int unsigned start;
    octet_q_t    q;
    frame_kind_t kind;
    logic [7:0]  len;
    int          cut;
    start = bytes_sent;
    if (pressure) begin
      // long receiver hold-off on a full-size frame, sender keeps pushing
      long_hold_req = 1'b1;
      send_all(frame_bytes(pick_addr(1'b1), 8'(MAX_LEN), 16'h0000));
    end
    while (bytes_sent - start < budget) begin
      dense = ($urandom_range(0, 4) == 0);
      kind = pick_kind();
      len = ($urandom_range(0, 5) == 0) ? 8'(MAX_LEN) : 8'($urandom_range(1, 6));
      case (kind)
        PK_GOOD:       q = frame_bytes(pick_addr(1'b1), len, 16'h0000);
        PK_BAD_CRC:    q = frame_bytes(pick_addr(1'b1), len,
                                       16'(1 << $urandom_range(0, 15)));
        PK_ZERO_LEN:   q = {HEADER_BYTE, pick_addr(1'b1), 8'h00};
        PK_LONG_LEN:   q = {HEADER_BYTE, pick_addr(1'b1),
                            $urandom_range(0, 1) ? 8'hFF : 8'($urandom_range(MAX_LEN + 1, 255))};
        PK_UNSELECTED: q = {HEADER_BYTE, pick_addr(1'b0)};
        PK_NOISE: begin
          q = {};
          repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
        end
        default: begin
          q = frame_bytes(pick_addr(1'b1), len, 16'h0000);
          cut = $urandom_range(1, q.size() - 1);
          repeat (cut) void'(q.pop_back());
        end
      endcase
      send_all(q);
    end
    flush_frame();
  endtask

  initial begin : result_sink
    int         gap;
    rx_result_t got;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        gap = LONG_HOLD;
        holds_done++;
      end else begin
        gap = dense ? 0 : $urandom_range(0, 16);
      end
      if (gap > 0) begin
        if (!out_stall) out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      got = '{out_status, out_payload_byte, out_byte_index, out_packet_length,
              out_respond_requested, out_last};
      sb.check_result(got);
    end
  end

  initial begin : stimulus
    logic [7:0] s_mask;
    logic [7:0] b_mask;
    sb = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_rx_byte    = 8'h00;
    cfg_valid     = 1'b0;
    cfg_index     = REG_SLAVE_MASK;
    cfg_wdata     = 8'h00;
    dense         = 1'b0;
    long_hold_req = 1'b0;
    holds_done    = 0;
    bytes_sent    = 0;
    settings_used = 1;
    cur_slave     = 8'h01;
    cur_board     = 8'hFF;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset masks: slave bit 0, any board bit
    send_all({8'h00, 8'hFF});
    send_all({HEADER_BYTE, 8'h02});
    send_all({HEADER_BYTE, 8'h01, 8'h00});
    send_all({HEADER_BYTE, 8'h81, 8'(MAX_LEN + 1)});
    send_all(frame_bytes(8'h01, 8'd1, 16'h0100));
    send_all(frame_bytes(8'hFF, 8'd2, 16'h0000));

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: begin s_mask = 8'hFF; b_mask = 8'hFF; end
        1: begin s_mask = 8'h00; b_mask = 8'hFF; end
        2: begin s_mask = 8'hFF; b_mask = 8'h00; end
        3: begin s_mask = 8'h80; b_mask = 8'h80; end
        default: begin
          s_mask = 8'($urandom_range(1, 255));
          b_mask = 8'($urandom_range(1, 255));
        end
      endcase
      wait_drained(SETTLE);
      cfg_write(REG_SLAVE_MASK, s_mask, 1'b1);
      cfg_write(REG_BOARD_MASK, b_mask, p == 0);
      if (p == 0) cfg_write(REG_UNUSED, 8'($urandom_range(0, 255)), 1'b0);
      cur_slave = s_mask;
      cur_board = b_mask;
      settings_used++;
      random_traffic((p == 1 || p == 2) ? 8 : 20, p == 0 || p == 4);
    end

    wait_drained(SETTLE);
    $display("covered %0d input beats and %0d result beats over %0d mask settings",
             bytes_sent, sb.results_seen, settings_used);
    $display("frames good, corrupted, truncated and unselected, %0d long output hold-offs",
             holds_done);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
